>>> rtl/kldb_pkg.sv
package kldb_pkg;

   // Number of keys served side by side; it also sets the width of every mask.
   localparam int KEY_COUNT = 2;

   // Width of the elapsed-tick counter and of the timing registers.
   localparam int TICK_WIDTH = 16;
   localparam logic [TICK_WIDTH-1:0] TICK_MAX = {TICK_WIDTH{1'b1}};

   // Register file of the control port.
   localparam int CSR_INDEX_WIDTH = 4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DEBOUNCE_TICKS = 4'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LONG_PRESS_TICKS = 4'd1;
   localparam logic [TICK_WIDTH-1:0] DEBOUNCE_RESET = 16'd20;
   localparam logic [TICK_WIDTH-1:0] LONG_PRESS_RESET = 16'd1000;

   // Pin level that means a key is pressed.
   localparam logic LOW = 1'b0;

   typedef logic [KEY_COUNT-1:0] key_mask_type;

   // Per-key phase, one-hot.
   typedef enum logic [4:0] {
      PH_UP       = 5'b00001,
      PH_DEB_DOWN = 5'b00010,
      PH_DOWN     = 5'b00100,
      PH_LONG     = 5'b01000,
      PH_DEB_UP   = 5'b10000
   } phase_type;

   // What one lane reports for the current tick.
   typedef struct packed {
      logic press;
      logic long_press;
      logic release_ev;
      logic held;
      logic long_held;
   } lane_result_type;

   // One merged result word.
   typedef struct packed {
      key_mask_type press_events;
      key_mask_type long_press_events;
      key_mask_type release_events;
      key_mask_type held_mask;
      key_mask_type long_held_mask;
   } rsp_word_type;

endpackage

>>> rtl/kldb_lane.sv
module kldb_lane (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             tick_take,
   input  logic                             key_level,
   input  logic [kldb_pkg::TICK_WIDTH-1:0]  debounce_ticks,
   input  logic [kldb_pkg::TICK_WIDTH-1:0]  long_press_ticks,
   output kldb_pkg::lane_result_type        result
);
   import kldb_pkg::*;

   phase_type             phase_ff;
   phase_type             phase_in;
   logic [TICK_WIDTH-1:0] elapsed_ff;
   logic [TICK_WIDTH-1:0] elapsed_in;
   logic [TICK_WIDTH-1:0] elapsed_adv;
   logic                  key_low;

   assign key_low = (key_level == LOW);

   // Saturating advance of the elapsed-tick counter.
   assign elapsed_adv = (elapsed_ff == TICK_MAX) ? elapsed_ff : elapsed_ff + 1'b1;

   // Phase transitions and events for this tick.
   always_comb begin
      phase_in          = phase_ff;
      elapsed_in        = elapsed_adv;
      result.press      = 1'b0;
      result.long_press = 1'b0;
      result.release_ev = 1'b0;
      unique case (phase_ff)
         PH_DEB_DOWN: begin
            if (!key_low) begin
               phase_in = PH_UP;
            end else if (elapsed_adv > debounce_ticks) begin
               phase_in     = PH_DOWN;
               result.press = 1'b1;
            end
         end
         PH_DOWN: begin
            if (!key_low) begin
               phase_in   = PH_DEB_UP;
               elapsed_in = '0;
            end else if (elapsed_adv > long_press_ticks) begin
               phase_in          = PH_LONG;
               result.long_press = 1'b1;
            end
         end
         PH_LONG: begin
            if (!key_low) begin
               phase_in   = PH_DEB_UP;
               elapsed_in = '0;
            end
         end
         PH_DEB_UP: begin
            if (key_low) begin
               elapsed_in = '0;
            end else if (elapsed_adv > debounce_ticks) begin
               phase_in          = PH_UP;
               result.release_ev = 1'b1;
            end
         end
         default: begin
            // Up, and any code that should never be held, behave as up.
            if (key_low) begin
               phase_in   = PH_DEB_DOWN;
               elapsed_in = '0;
            end else begin
               phase_in = PH_UP;
            end
         end
      endcase
      result.held      = (phase_in == PH_DOWN) || (phase_in == PH_LONG);
      result.long_held = (phase_in == PH_LONG);
   end

   // Lane state advances once per accepted tick word.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_UP;
         elapsed_ff <= '0;
      end else if (tick_take) begin
         phase_ff   <= phase_in;
         elapsed_ff <= elapsed_in;
      end
   end

`ifndef SYNTHESIS
   a_press_enters_down: assert property (@(posedge clock) disable iff (reset)
      tick_take && result.press |=> phase_ff == PH_DOWN)
      else $error("press event did not lead to the down phase");
   a_first_low_restarts: assert property (@(posedge clock) disable iff (reset)
      tick_take && phase_ff == PH_UP && key_low |=> elapsed_ff == '0)
      else $error("counter not restarted when a press was first seen");
   a_idle_holds_state: assert property (@(posedge clock) disable iff (reset)
      !tick_take |=> $stable(phase_ff) && $stable(elapsed_ff))
      else $error("lane state changed without an accepted tick");
`endif

endmodule

>>> rtl/kldb_merge.sv
module kldb_merge (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         tick_take,
   input  kldb_pkg::lane_result_type [kldb_pkg::KEY_COUNT-1:0] lane_results,
   input  logic                                         rsp_stall,
   output logic                                         skid_full,
   output logic                                         rsp_valid,
   output kldb_pkg::rsp_word_type                       rsp_word
);
   import kldb_pkg::*;

   rsp_word_type merged;
   rsp_word_type out_ff;
   rsp_word_type skid_ff;
   logic         out_valid_ff;
   logic         skid_valid_ff;
   logic         rsp_take;
   logic         out_free;

   // Gather the per-lane bits into the result masks.
   always_comb begin
      for (int k = 0; k < KEY_COUNT; k++) begin
         merged.press_events[k]      = lane_results[k].press;
         merged.long_press_events[k] = lane_results[k].long_press;
         merged.release_events[k]    = lane_results[k].release_ev;
         merged.held_mask[k]         = lane_results[k].held;
         merged.long_held_mask[k]    = lane_results[k].long_held;
      end
   end

   assign rsp_take  = out_valid_ff && !rsp_stall;
   assign out_free  = !out_valid_ff || rsp_take;
   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_ff;
   assign skid_full = skid_valid_ff;

   // Output register with a skid word behind it.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_take) begin
            out_ff        <= skid_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (tick_take) begin
         if (out_free) begin
            out_ff       <= merged;
            out_valid_ff <= 1'b1;
         end else begin
            skid_ff       <= merged;
            skid_valid_ff <= 1'b1;
         end
      end else if (rsp_take) begin
         out_valid_ff <= 1'b0;
      end
   end

`ifndef SYNTHESIS
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid word held while the output register is empty");
   a_stalled_tick_to_skid: assert property (@(posedge clock) disable iff (reset)
      tick_take && out_valid_ff && rsp_stall |=> skid_valid_ff)
      else $error("tick taken under stall was not parked in the skid word");
   a_skid_moves_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && !rsp_stall |=> out_ff == $past(skid_ff))
      else $error("skid word did not move to the output register");
`endif

endmodule

>>> rtl/key_debouncer_long_press.sv
// Debouncer with long-press detection, one lane per key.
// The result word for a tick is registered in the output register when that is free, else in the skid word.
// One tick word per cycle while req_stall is low; the per-key phase and counter are registered per tick.
// While a result waits, the output stage (register plus skid) takes one more tick,
// then stalls the input until the waiting word leaves.
// Reset is synchronous: all keys return to up with cleared counters, the timing
// registers return to 20 and 1000 ticks, and the output stage empties.
module key_debouncer_long_press (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [kldb_pkg::KEY_COUNT-1:0]       req_key_levels,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [kldb_pkg::KEY_COUNT-1:0]       rsp_press_events,
   output logic [kldb_pkg::KEY_COUNT-1:0]       rsp_long_press_events,
   output logic [kldb_pkg::KEY_COUNT-1:0]       rsp_release_events,
   output logic [kldb_pkg::KEY_COUNT-1:0]       rsp_held_mask,
   output logic [kldb_pkg::KEY_COUNT-1:0]       rsp_long_held_mask,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [kldb_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [kldb_pkg::TICK_WIDTH-1:0]      csr_data
);
   import kldb_pkg::*;

   logic [TICK_WIDTH-1:0]                debounce_ff;
   logic [TICK_WIDTH-1:0]                long_press_ff;
   logic                                 tick_take;
   logic                                 skid_full;
   lane_result_type [KEY_COUNT-1:0]      lane_results;
   rsp_word_type                         rsp_word;

   assign csr_ready = 1'b1;
   assign req_stall = skid_full;
   assign tick_take = req_valid && !req_stall;

   // Timing registers; writes to unknown indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff   <= DEBOUNCE_RESET;
         long_press_ff <= LONG_PRESS_RESET;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_DEBOUNCE_TICKS) begin
            debounce_ff <= csr_data;
         end else if (csr_index == CSR_LONG_PRESS_TICKS) begin
            long_press_ff <= csr_data;
         end
      end
   end

   // One lane per key.
   for (genvar k = 0; k < KEY_COUNT; k++) begin : g_lane
      kldb_lane u_lane (
         .clock            (clock),
         .reset            (reset),
         .tick_take        (tick_take),
         .key_level        (req_key_levels[k]),
         .debounce_ticks   (debounce_ff),
         .long_press_ticks (long_press_ff),
         .result           (lane_results[k])
      );
   end

   // Merge lane bits into the result word and buffer it.
   kldb_merge u_merge (
      .clock        (clock),
      .reset        (reset),
      .tick_take    (tick_take),
      .lane_results (lane_results),
      .rsp_stall    (rsp_stall),
      .skid_full    (skid_full),
      .rsp_valid    (rsp_valid),
      .rsp_word     (rsp_word)
   );

   assign rsp_press_events      = rsp_word.press_events;
   assign rsp_long_press_events = rsp_word.long_press_events;
   assign rsp_release_events    = rsp_word.release_events;
   assign rsp_held_mask         = rsp_word.held_mask;
   assign rsp_long_held_mask    = rsp_word.long_held_mask;

endmodule
